[design/ubrb_pkg.sv]
// ubrb_pkg: shared types and constants for the uart byte ring buffers unit
// no dependencies; used by uart_byte_ring_buffers_unit
`timescale 1ns / 1ps

package ubrb_pkg;

    // event codes carried by the op field
    typedef enum logic [1:0] {
        OP_HOST_WRITE = 2'd0,
        OP_HOST_READ  = 2'd1,
        OP_LINE_RX    = 2'd2,
        OP_TX_DONE    = 2'd3
    } op_t;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 4;

    // control carried from the memory read stage to the output register
    typedef struct packed {
        logic               rd_valid;     // host read found a byte in rx memory
        logic               send_from_in; // host write into an empty send ring
        logic               send_from_mem;// transmit done with a queued byte
        logic [BYTE_W-1:0]  in_byte;      // byte taken with the event
        logic [COUNT_W-1:0] rx_count;
        logic               tx_dropped;
        logic               rx_overwrote;
        logic               rx_notify;
    } stage_ctrl_t;

endpackage

[design/uart_byte_ring_buffers_unit.sv]
// uart_byte_ring_buffers_unit: send and receive byte rings in two synchronous memories
// depends on ubrb_pkg for the event codes and the stage control struct
`timescale 1ns / 1ps

// Takes one event per cycle on the in channel while in_ready is high and returns
// exactly one result per event on the out channel, through the stage register and then
// the output register. The sustained rate is one event per clock while the out side is
// not stalled; it is set by the single read or write port use of each event on its ring
// memory (registered read) and the pointer update, which both finish in the transfer
// cycle. The send and receive rings hold at most DEPTH-1 bytes each; memory contents are
// undefined until written, and no clearing pass is needed after reset.
module uart_byte_ring_buffers_unit #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // event channel
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  op,
    input  logic [ubrb_pkg::BYTE_W-1:0] data_byte,
    // result channel
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ubrb_pkg::BYTE_W-1:0] read_data,
    output logic                        read_valid,
    output logic                        send_start,
    output logic [ubrb_pkg::BYTE_W-1:0] send_byte,
    output logic [ubrb_pkg::COUNT_W-1:0] rx_count,
    output logic                        tx_dropped,
    output logic                        rx_overwrote,
    output logic                        rx_notify
);

    localparam int unsigned PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = (PW + 1 > ubrb_pkg::COUNT_W) ? PW + 1 : ubrb_pkg::COUNT_W;
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

    // ring memories
    logic [ubrb_pkg::BYTE_W-1:0] rx_mem [DEPTH];
    logic [ubrb_pkg::BYTE_W-1:0] tx_mem [DEPTH];
    logic [ubrb_pkg::BYTE_W-1:0] rx_rdata_reg;
    logic [ubrb_pkg::BYTE_W-1:0] tx_rdata_reg;

    // ring pointers
    logic [PW-1:0] rx_head_reg, rx_head_next;
    logic [PW-1:0] rx_tail_reg, rx_tail_next;
    logic [PW-1:0] tx_head_reg, tx_head_next;
    logic [PW-1:0] tx_tail_reg, tx_tail_next;

    // pipeline control
    logic                  s1_valid_reg, s1_valid_next;
    ubrb_pkg::stage_ctrl_t s1_ctrl_reg, s1_ctrl_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  s1_move;
    logic                  in_xfer;

    // memory access requests
    logic          rx_we, rx_re, tx_we, tx_re;
    logic [PW-1:0] tx_raddr;

    // ring step helpers
    logic [PW-1:0] rx_tail_inc, rx_head_inc, tx_tail_inc, tx_head_inc;
    logic [CW-1:0] fill_diff;

    ubrb_pkg::op_t op_code;

    assign op_code = ubrb_pkg::op_t'(op);

    // handshake
    assign s1_move   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_move;
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // wrapping increments
    assign rx_tail_inc = (rx_tail_reg == LAST_PTR) ? '0 : rx_tail_reg + 1'b1;
    assign rx_head_inc = (rx_head_reg == LAST_PTR) ? '0 : rx_head_reg + 1'b1;
    assign tx_tail_inc = (tx_tail_reg == LAST_PTR) ? '0 : tx_tail_reg + 1'b1;
    assign tx_head_inc = (tx_head_reg == LAST_PTR) ? '0 : tx_head_reg + 1'b1;

    // event decode and pointer update
    always_comb
    begin
        rx_head_next = rx_head_reg;
        rx_tail_next = rx_tail_reg;
        tx_head_next = tx_head_reg;
        tx_tail_next = tx_tail_reg;
        rx_we        = 1'b0;
        rx_re        = 1'b0;
        tx_we        = 1'b0;
        tx_re        = 1'b0;
        tx_raddr     = tx_head_inc;
        s1_ctrl_next = '0;
        s1_ctrl_next.in_byte = data_byte;
        if (in_xfer)
        begin
            case (op_code)
                ubrb_pkg::OP_HOST_WRITE:
                begin
                    if (tx_tail_inc != tx_head_reg)
                    begin
                        tx_we        = 1'b1;
                        tx_tail_next = tx_tail_inc;
                        s1_ctrl_next.send_from_in = (tx_tail_reg == tx_head_reg);
                    end
                    else
                    begin
                        s1_ctrl_next.tx_dropped = 1'b1;
                    end
                end
                ubrb_pkg::OP_HOST_READ:
                begin
                    if (rx_head_reg != rx_tail_reg)
                    begin
                        rx_re        = 1'b1;
                        rx_head_next = rx_head_inc;
                        s1_ctrl_next.rd_valid = 1'b1;
                    end
                end
                ubrb_pkg::OP_LINE_RX:
                begin
                    rx_we        = 1'b1;
                    rx_tail_next = rx_tail_inc;
                    if (rx_tail_inc == rx_head_reg)
                    begin
                        rx_head_next = rx_head_inc;
                        s1_ctrl_next.rx_overwrote = 1'b1;
                    end
                    s1_ctrl_next.rx_notify = 1'b1;
                end
                ubrb_pkg::OP_TX_DONE:
                begin
                    if (tx_head_reg != tx_tail_reg)
                    begin
                        tx_head_next = tx_head_inc;
                        if (tx_head_inc != tx_tail_reg)
                        begin
                            tx_re = 1'b1;
                            s1_ctrl_next.send_from_mem = 1'b1;
                        end
                    end
                end
                default:
                begin
                    s1_ctrl_next = '0;
                end
            endcase
        end
        // receive fill after the event
        fill_diff = CW'(rx_tail_next) - CW'(rx_head_next);
        if (rx_tail_next < rx_head_next)
        begin
            fill_diff = fill_diff + DEPTH_C;
        end
        s1_ctrl_next.rx_count = fill_diff[ubrb_pkg::COUNT_W-1:0];
    end

    // stage valids
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_head_reg   <= '0;
            rx_tail_reg   <= '0;
            tx_head_reg   <= '0;
            tx_tail_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rx_head_reg   <= rx_head_next;
            rx_tail_reg   <= rx_tail_next;
            tx_head_reg   <= tx_head_next;
            tx_tail_reg   <= tx_tail_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // stage control held until it moves to the output
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_ctrl_reg <= s1_ctrl_next;
        end
    end

    // receive ring memory, one write or one registered read per event
    always_ff @(posedge clk)
    begin
        if (rx_we)
        begin
            rx_mem[rx_tail_reg] <= data_byte;
        end
        if (rx_re)
        begin
            rx_rdata_reg <= rx_mem[rx_head_reg];
        end
    end

    // send ring memory, one write or one registered read per event
    always_ff @(posedge clk)
    begin
        if (tx_we)
        begin
            tx_mem[tx_tail_reg] <= data_byte;
        end
        if (tx_re)
        begin
            tx_rdata_reg <= tx_mem[tx_raddr];
        end
    end

    // output register, loaded when the stage result transfers forward
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            read_data    <= s1_ctrl_reg.rd_valid ? rx_rdata_reg : '0;
            read_valid   <= s1_ctrl_reg.rd_valid;
            send_start   <= s1_ctrl_reg.send_from_in || s1_ctrl_reg.send_from_mem;
            send_byte    <= s1_ctrl_reg.send_from_mem ? tx_rdata_reg :
                            (s1_ctrl_reg.send_from_in ? s1_ctrl_reg.in_byte : '0);
            rx_count     <= s1_ctrl_reg.rx_count;
            tx_dropped   <= s1_ctrl_reg.tx_dropped;
            rx_overwrote <= s1_ctrl_reg.rx_overwrote;
            rx_notify    <= s1_ctrl_reg.rx_notify;
        end
    end

    // pointers stay inside the ring
    assert property (@(posedge clk) disable iff (!rst_n)
        (rx_head_reg <= LAST_PTR) && (rx_tail_reg <= LAST_PTR) &&
        (tx_head_reg <= LAST_PTR) && (tx_tail_reg <= LAST_PTR))
        else $error("ring pointer beyond last slot");

    // a stalled stage must block new transfers
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move) |-> !in_ready)
        else $error("transfer accepted over a stalled stage");

    // a write leaves the send ring not empty
    assert property (@(posedge clk) disable iff (!rst_n)
        tx_we |=> (tx_tail_reg != tx_head_reg))
        else $error("send ring reads empty right after a write");

    // at most one kind of event flag per result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0({read_valid, send_start, tx_dropped, rx_notify}))
        else $error("result carries flags of more than one event");

    // a received byte is always counted when DEPTH is at most 16
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && rx_notify) |-> (rx_count != '0 || DEPTH > 16))
        else $error("receive event left an empty count");

endmodule
